// ===== src/b2da_pkg.sv =====
package b2da_pkg;

   localparam int VALUE_W    = 64;
   localparam int NUM_DIGITS = 20;
   localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);
   localparam int CNT_W      = $clog2(VALUE_W + 1);
   localparam int FLEN_W     = 6;
   localparam int CHAR_W     = 8;
   localparam int DEF_MAX_LEN = 32;

   localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] ASCII_NUL  = 8'h00;

   localparam logic MODE_PADDED   = 1'b0;
   localparam logic MODE_UNPADDED = 1'b1;

   typedef logic [NUM_DIGITS-1:0][3:0] bcd_type;

endpackage

// ===== src/b2da_dabble.sv =====
module b2da_dabble
   import b2da_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [VALUE_W-1:0] value,
   output logic               done,
   output bcd_type            bcd
);

   logic [VALUE_W-1:0] bin_ff, bin_in;
   bcd_type            bcd_ff, bcd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               done_ff, done_in;
   bcd_type            adj;

   // add 3 to every digit of 5 or more, then shift one bit in
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         bin_in = value;
         bcd_in = '0;
         cnt_in = CNT_W'(VALUE_W);
      end else if (cnt_ff != '0) begin
         bcd_in[0] = {adj[0][2:0], bin_ff[VALUE_W-1]};
         for (int i = 1; i < NUM_DIGITS; i++) begin
            bcd_in[i] = {adj[i][2:0], adj[i-1][3]};
         end
         bin_in  = {bin_ff[VALUE_W-2:0], 1'b0};
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule

// ===== src/binary_to_decimal_ascii_unit.sv =====
// sequence: take the word, convert it with the bit-serial shift-add-3 converter,
// hand over, scan for the leading digit one digit a cycle, then emit one byte
// per cycle while rsp_stall is low; a new word is taken only after the last
// byte of the previous one is out, and req_stall is high until then
// reset: synchronous, clears the sequencer and the output valid
module binary_to_decimal_ascii_unit
   import b2da_pkg::*;
#(
   parameter int MAX_LEN = DEF_MAX_LEN
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_mode,
   input  logic [VALUE_W-1:0] req_value,
   input  logic [FLEN_W-1:0]  req_field_len,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [CHAR_W-1:0]  rsp_char_out,
   output logic               rsp_last
);

   localparam int LEN_W = $clog2(MAX_LEN + 1);
   localparam int SEL_W = (LEN_W > DIG_IDX_W) ? LEN_W : DIG_IDX_W;
   localparam int CMP_W = FLEN_W + 1;
   localparam int SIG_W = $clog2(NUM_DIGITS + 1);

   typedef enum logic [1:0] {IDLE, CONV, SCAN, EMIT} state_type;

   state_type          state_ff, state_in;
   logic               mode_ff, mode_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [LEN_W-1:0]   rem_ff, rem_in;
   logic [LEN_W-1:0]   ndig_ff, ndig_in;
   logic [SIG_W-1:0]   sig_ff, sig_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic               last_ff, last_in;

   logic               start;
   logic               conv_done;
   bcd_type            bcd;
   logic [SEL_W-1:0]   sel;
   logic [3:0]         digit_val;
   logic [LEN_W-1:0]   len_sat;
   logic [SEL_W-1:0]   sig_ext, lenm1_ext, keep;
   logic               accept;
   logic               out_free;

   b2da_dabble u_dabble (
      .clock (clock),
      .reset (reset),
      .start (start),
      .value (req_value),
      .done  (conv_done),
      .bcd   (bcd)
   );

   assign accept   = req_valid && (state_ff == IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign len_sat = ({1'b0, req_field_len} > CMP_W'(MAX_LEN)) ?
                    LEN_W'(MAX_LEN) : LEN_W'(req_field_len);
   assign start   = accept && (len_sat != '0);

   // one digit select shared by the scan and the byte output
   always_comb begin
      if (state_ff == SCAN) begin
         sel = SEL_W'(sig_ff) - SEL_W'(1);
      end else begin
         sel = SEL_W'(ndig_ff) - SEL_W'(1);
      end
      digit_val = (sel < SEL_W'(NUM_DIGITS)) ? bcd[sel[DIG_IDX_W-1:0]] : 4'd0;
   end

   assign sig_ext   = SEL_W'(sig_ff);
   assign lenm1_ext = SEL_W'(len_ff - LEN_W'(1));
   assign keep      = (sig_ext < lenm1_ext) ? sig_ext : lenm1_ext;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      len_in       = len_ff;
      rem_in       = rem_ff;
      ndig_in      = ndig_ff;
      sig_in       = sig_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      char_in      = char_ff;
      last_in      = last_ff;
      case (state_ff)
         IDLE: begin
            if (start) begin
               mode_in  = req_mode;
               len_in   = len_sat;
               state_in = CONV;
            end
         end
         CONV: begin
            if (conv_done) begin
               sig_in   = SIG_W'(NUM_DIGITS);
               state_in = SCAN;
            end
         end
         SCAN: begin
            if (sig_ff == '0 || digit_val != 4'd0) begin
               if (mode_ff == MODE_PADDED) begin
                  ndig_in = len_ff - LEN_W'(1);
               end else if (sig_ff == '0) begin
                  ndig_in = LEN_W'(1);
               end else begin
                  ndig_in = LEN_W'(keep);
               end
               rem_in   = len_ff;
               state_in = EMIT;
            end else begin
               sig_in = sig_ff - SIG_W'(1);
            end
         end
         EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               char_in      = (ndig_ff != '0) ? ASCII_ZERO + CHAR_W'(digit_val) : ASCII_NUL;
               last_in      = (rem_ff == LEN_W'(1));
               if (ndig_ff != '0) begin
                  ndig_in = ndig_ff - LEN_W'(1);
               end
               rem_in = rem_ff - LEN_W'(1);
               if (rem_ff == LEN_W'(1)) begin
                  state_in = IDLE;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff <= mode_in;
      len_ff  <= len_in;
      rem_ff  <= rem_in;
      ndig_ff <= ndig_in;
      sig_ff  <= sig_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign req_stall    = (state_ff != IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_char_out = char_ff;
   assign rsp_last     = last_ff;

endmodule
